### src/hbsa_pkg.sv
// ============================================================================
// hbsa_pkg
// Shared types, constants and a helper function for the slot allocator.
// ============================================================================
`default_nettype none

package hbsa_pkg;

    // Geometry of the two-level bitmap.
    localparam int WORD_BITS     = 32;
    localparam int WIDX_W        = $clog2(WORD_BITS);
    localparam int LEAF_WORDS    = WORD_BITS;
    localparam int LEAF_ADDR_W   = $clog2(LEAF_WORDS);
    localparam int SLOT_COUNT    = LEAF_WORDS * WORD_BITS;
    localparam int SLOT_W        = $clog2(SLOT_COUNT);
    localparam int COUNT_W       = SLOT_W + 1;
    localparam int GEN_W         = 8;
    localparam int HANDLE_W      = 32;
    localparam int HANDLE_SLOT_W = 24;

    typedef enum logic [1:0] {
        KIND_ALLOC    = 2'd0,
        KIND_FREE     = 2'd1,
        KIND_FREE_ALL = 2'd2,
        KIND_LOOKUP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_STALE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_GEN
    } state_t;

    // Write request for the leaf bitmap store.
    typedef struct packed {
        logic                   en;
        logic [LEAF_ADDR_W-1:0] addr;
        logic [WORD_BITS-1:0]   data;
    } leaf_wr_t;

    // Write request for the generation store.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [GEN_W-1:0]  data;
    } gen_wr_t;

    // Index of the lowest clear bit; the top index when every bit is set.
    function automatic logic [WIDX_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
        logic [WIDX_W-1:0] r;
        r = WIDX_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 2; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = WIDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/hbsa_leaf_mem.sv
// ============================================================================
// hbsa_leaf_mem
// Leaf bitmap store: one used bit per slot, with a valid bit per word so that
// reset and free-all clear the whole store at once.
// ============================================================================
`default_nettype none

module hbsa_leaf_mem (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   rd_en,
    input  wire  [hbsa_pkg::LEAF_ADDR_W-1:0]      rd_addr,
    output logic [hbsa_pkg::WORD_BITS-1:0]        rd_data,
    input  hbsa_pkg::leaf_wr_t                    wr,
    input  wire                                   clear_all
);
    import hbsa_pkg::*;

    logic [WORD_BITS-1:0]  mem [LEAF_WORDS];
    logic [LEAF_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0]  data_reg;
    logic                  data_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear_all)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_reg       <= mem[rd_addr];
            data_valid_reg <= valid_reg[rd_addr];
        end
    end

    // A word never written since the last clear reads as all free.
    assign rd_data = data_valid_reg ? data_reg : '0;

endmodule

`default_nettype wire

### src/hbsa_gen_mem.sv
// ============================================================================
// hbsa_gen_mem
// Generation store: one generation offset per slot, single write port and a
// registered read port.
// ============================================================================
`default_nettype none

module hbsa_gen_mem (
    input  wire                              clk,
    input  wire                              rd_en,
    input  wire  [hbsa_pkg::SLOT_W-1:0]      rd_addr,
    output logic [hbsa_pkg::GEN_W-1:0]       rd_data,
    input  hbsa_pkg::gen_wr_t                wr
);
    import hbsa_pkg::*;

    logic [GEN_W-1:0] mem [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/hierarchical_bitmap_slot_allocator_top.sv
// ============================================================================
// hierarchical_bitmap_slot_allocator_top
// Slot allocator over 1024 slots with a two-level bitmap and per-slot
// generations; returns generation-tagged handles.
// ============================================================================
// From the accepting edge to the result strobe, allocate passes through the
// READ, EVAL and GEN states, free and lookup through READ and EVAL, and
// free-all and a full-store allocate through READ alone. One item is in
// flight at a time; the next may start in the strobe cycle, so the allocate
// rate is set by the leaf read followed by the dependent generation read.
// Results cannot be stalled by the receiver. After reset the block is busy
// while it zeroes the generation store, one entry per cycle.
`default_nettype none

module hierarchical_bitmap_slot_allocator_top (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire  [1:0]                           kind,
    input  wire  [hbsa_pkg::HANDLE_W-1:0]        handle_in,
    input  wire  [hbsa_pkg::SLOT_W-1:0]          slot_in,
    output logic                                 strobe,
    output logic [1:0]                           status,
    output logic [hbsa_pkg::HANDLE_W-1:0]        handle_out,
    output logic [hbsa_pkg::SLOT_W-1:0]          slot_out,
    output logic [hbsa_pkg::COUNT_W-1:0]         live_count
);
    import hbsa_pkg::*;

    // The top bitmap word lives in flip-flops; a set bit means that leaf word
    // is full. The leaf words and the generations sit in the two memories.
    //
    // Free-all advances every generation by bumping a global epoch: the
    // generation of a slot is its stored offset plus the epoch, modulo 256.
    // A single free writes back the stored offset plus one.

    state_t state_reg, state_next;

    logic [WORD_BITS-1:0] summary_reg, summary_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [GEN_W-1:0]     epoch_reg, epoch_next;
    logic [SLOT_W-1:0]    clr_cnt_reg, clr_cnt_next;

    kind_t                kind_reg, kind_next;
    logic [SLOT_W-1:0]    op_slot_reg, op_slot_next;
    logic [GEN_W-1:0]     gen_in_reg, gen_in_next;
    logic                 bad_range_reg, bad_range_next;

    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [SLOT_W-1:0]    slot_out_reg, slot_out_next;

    logic                   leaf_rd_en;
    logic [LEAF_ADDR_W-1:0] leaf_rd_addr;
    logic [WORD_BITS-1:0]   leaf_rd_data;
    leaf_wr_t               leaf_wr;
    logic                   leaf_clear_all;

    logic                   gen_rd_en;
    logic [SLOT_W-1:0]      gen_rd_addr;
    logic [GEN_W-1:0]       gen_rd_data;
    gen_wr_t                gen_wr;

    logic                   summary_full;
    logic [WIDX_W-1:0]      free_bit;
    logic [WORD_BITS-1:0]   alloc_word;
    logic [GEN_W-1:0]       gen_cur;
    logic [LEAF_ADDR_W-1:0] op_word;
    logic [WIDX_W-1:0]      op_bit;
    logic                   free_ok;

    hbsa_leaf_mem u_leaf_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (leaf_rd_en),
        .rd_addr   (leaf_rd_addr),
        .rd_data   (leaf_rd_data),
        .wr        (leaf_wr),
        .clear_all (leaf_clear_all)
    );

    hbsa_gen_mem u_gen_mem (
        .clk     (clk),
        .rd_en   (gen_rd_en),
        .rd_addr (gen_rd_addr),
        .rd_data (gen_rd_data),
        .wr      (gen_wr)
    );

    // Shared decode of the word just read and the item held.
    assign summary_full = &summary_reg;
    assign op_word      = op_slot_reg[SLOT_W-1:WIDX_W];
    assign op_bit       = op_slot_reg[WIDX_W-1:0];
    assign free_bit     = lowest_clear(leaf_rd_data);
    assign alloc_word   = leaf_rd_data | (WORD_BITS'(1) << free_bit);
    assign gen_cur      = gen_rd_data + epoch_reg;
    assign free_ok      = !bad_range_reg && (gen_in_reg == gen_cur) && leaf_rd_data[op_bit];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if ((kind_reg == KIND_FREE_ALL) || (kind_reg == KIND_ALLOC && summary_full))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    state_next = ST_GEN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GEN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath logic: memory accesses and register updates.
    always_comb
    begin
        leaf_rd_en     = 1'b0;
        leaf_rd_addr   = op_word;
        leaf_wr        = '0;
        leaf_clear_all = 1'b0;
        gen_rd_en      = 1'b0;
        gen_rd_addr    = op_slot_reg;
        gen_wr         = '0;

        summary_next   = summary_reg;
        count_next     = count_reg;
        epoch_next     = epoch_reg;
        clr_cnt_next   = clr_cnt_reg;
        kind_next      = kind_reg;
        op_slot_next   = op_slot_reg;
        gen_in_next    = gen_in_reg;
        bad_range_next = bad_range_reg;

        done_next      = 1'b0;
        status_next    = status_reg;
        handle_next    = handle_reg;
        slot_out_next  = slot_out_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                gen_wr.en    = 1'b1;
                gen_wr.addr  = clr_cnt_reg;
                gen_wr.data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next      = kind_t'(kind);
                    gen_in_next    = handle_in[HANDLE_W-1:HANDLE_SLOT_W];
                    bad_range_next = (handle_in[HANDLE_SLOT_W-1:SLOT_W] != '0);
                    case (kind_t'(kind))
                        KIND_ALLOC:
                        begin
                            // Descend the top level now; the summary is stable.
                            op_slot_next = {lowest_clear(summary_reg), {WIDX_W{1'b0}}};
                        end
                        KIND_FREE:
                        begin
                            op_slot_next = handle_in[SLOT_W-1:0];
                        end
                        default:
                        begin
                            op_slot_next = slot_in;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                leaf_rd_en = 1'b1;
                gen_rd_en  = 1'b1;
                if (kind_reg == KIND_FREE_ALL)
                begin
                    leaf_clear_all = 1'b1;
                    summary_next   = '0;
                    epoch_next     = epoch_reg + 1'b1;
                    count_next     = '0;
                    done_next      = 1'b1;
                    status_next    = STAT_OK;
                    handle_next    = '0;
                    slot_out_next  = '0;
                end
                else if (kind_reg == KIND_ALLOC && summary_full)
                begin
                    done_next     = 1'b1;
                    status_next   = STAT_FULL;
                    handle_next   = '0;
                    slot_out_next = '0;
                end
            end
            ST_EVAL:
            begin
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        leaf_wr.en   = 1'b1;
                        leaf_wr.addr = op_word;
                        leaf_wr.data = alloc_word;
                        if (&alloc_word)
                        begin
                            summary_next[op_word] = 1'b1;
                        end
                        count_next   = count_reg + 1'b1;
                        op_slot_next = {op_word, free_bit};
                        gen_rd_en    = 1'b1;
                        gen_rd_addr  = {op_word, free_bit};
                    end
                    KIND_FREE:
                    begin
                        done_next   = 1'b1;
                        handle_next = '0;
                        if (free_ok)
                        begin
                            leaf_wr.en            = 1'b1;
                            leaf_wr.addr          = op_word;
                            leaf_wr.data          = leaf_rd_data & ~(WORD_BITS'(1) << op_bit);
                            gen_wr.en             = 1'b1;
                            gen_wr.addr           = op_slot_reg;
                            gen_wr.data           = gen_rd_data + 1'b1;
                            summary_next[op_word] = 1'b0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            status_next   = STAT_OK;
                            slot_out_next = op_slot_reg;
                        end
                        else
                        begin
                            status_next   = STAT_STALE;
                            slot_out_next = '0;
                        end
                    end
                    default:
                    begin
                        done_next     = 1'b1;
                        slot_out_next = '0;
                        if (leaf_rd_data[op_bit])
                        begin
                            status_next = STAT_OK;
                            handle_next = {gen_cur, {(HANDLE_SLOT_W - SLOT_W){1'b0}}, op_slot_reg};
                        end
                        else
                        begin
                            status_next = STAT_STALE;
                            handle_next = '0;
                        end
                    end
                endcase
            end
            ST_GEN:
            begin
                done_next     = 1'b1;
                status_next   = STAT_OK;
                handle_next   = {gen_cur, {(HANDLE_SLOT_W - SLOT_W){1'b0}}, op_slot_reg};
                slot_out_next = op_slot_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            summary_reg <= '0;
            count_reg   <= '0;
            epoch_reg   <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            summary_reg <= summary_next;
            count_reg   <= count_next;
            epoch_reg   <= epoch_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        op_slot_reg   <= op_slot_next;
        gen_in_reg    <= gen_in_next;
        bad_range_reg <= bad_range_next;
        status_reg    <= status_next;
        handle_reg    <= handle_next;
        slot_out_reg  <= slot_out_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = done_reg;
    assign status     = status_reg;
    assign handle_out = handle_reg;
    assign slot_out   = slot_out_reg;
    assign live_count = count_reg;

    // A result transfer always lands in an idle cycle, once the item is done.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result strobe while an item is still in progress");

    // The top word is all ones exactly when every slot is counted as in use.
    a_summary_count: assert property (@(posedge clk) disable iff (!rst_n)
        summary_full == (count_reg == COUNT_W'(SLOT_COUNT)))
        else $error("summary word disagrees with the live count");

    // A store-full answer only when the count says the store is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == STAT_FULL) |-> (live_count == COUNT_W'(SLOT_COUNT)))
        else $error("full status reported with free slots left");

    // An allocate adds exactly one to the count.
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && kind_reg == KIND_ALLOC) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("allocate did not advance the live count by one");

endmodule

`default_nettype wire

### verif/tb_hierarchical_bitmap_slot_allocator_top.sv
// ============================================================================
// tb_hierarchical_bitmap_slot_allocator_top
// Self-checking testbench for the slot allocator. A ledger class mirrors the
// bitmaps, generations and live count, predicts one answer per accepted
// command and checks every strobed result against the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

import hbsa_pkg::*;

// One predicted answer of the allocator.
typedef struct {
    status_t               status;
    logic [HANDLE_W-1:0]   handle;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    count;
} answer_t;

class slot_ledger;
    logic [WORD_BITS-1:0] leaf_used [LEAF_WORDS];
    logic [WORD_BITS-1:0] full_marks;
    logic [GEN_W-1:0]     gen_of [SLOT_COUNT];
    int unsigned          live;
    answer_t              pending_answers [$];
    int unsigned          mismatches;
    int unsigned          answers_seen;
    int unsigned          n_alloc, n_full, n_free, n_refused, n_clear, n_lookup, n_wraps;

    function new();
        foreach (leaf_used[i])
        begin
            leaf_used[i] = '0;
        end
        foreach (gen_of[i])
        begin
            gen_of[i] = '0;
        end
        full_marks = '0;
        live       = 0;
    endfunction

    function int unsigned lowest_zero(logic [WORD_BITS-1:0] w);
        int unsigned pos;
        pos = 0;
        while (pos < WORD_BITS - 1 && w[pos])
        begin
            pos++;
        end
        return pos;
    endfunction

    function bit in_use(int unsigned s);
        return leaf_used[s / WORD_BITS][s % WORD_BITS];
    endfunction

    function logic [HANDLE_W-1:0] handle_of(int unsigned s);
        return {gen_of[s], HANDLE_SLOT_W'(s)};
    endfunction

    // Scans upwards from a start slot, wrapping; -1 when nothing matches.
    function int find_slot(int unsigned from, bit want_used);
        int unsigned s;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            s = (from + i) % SLOT_COUNT;
            if (in_use(s) == want_used)
            begin
                return int'(s);
            end
        end
        return -1;
    endfunction

    function int unsigned outstanding();
        return pending_answers.size();
    endfunction

    function answer_t predict_answer(kind_t k, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] s);
        answer_t     a;
        int unsigned top;
        int unsigned idx;
        int unsigned hs;
        logic [7:0]  hg;
        a.status = STAT_OK;
        a.handle = '0;
        a.slot   = '0;
        case (k)
            KIND_ALLOC:
            begin
                n_alloc++;
                if (&full_marks)
                begin
                    a.status = STAT_FULL;
                    n_full++;
                end
                else
                begin
                    top = lowest_zero(full_marks);
                    idx = top * WORD_BITS + lowest_zero(leaf_used[top]);
                    leaf_used[top][idx % WORD_BITS] = 1'b1;
                    if (&leaf_used[top])
                    begin
                        full_marks[top] = 1'b1;
                    end
                    live++;
                    a.handle = handle_of(idx);
                    a.slot   = SLOT_W'(idx);
                end
            end
            KIND_FREE:
            begin
                n_free++;
                hs = int'(h[HANDLE_SLOT_W-1:0]);
                hg = h[HANDLE_W-1:HANDLE_SLOT_W];
                if (hs >= SLOT_COUNT)
                begin
                    a.status = STAT_STALE;
                end
                else if (hg != gen_of[hs] || !in_use(hs))
                begin
                    a.status = STAT_STALE;
                end
                else
                begin
                    if (gen_of[hs] == '1)
                    begin
                        n_wraps++;
                    end
                    gen_of[hs]++;
                    leaf_used[hs / WORD_BITS][hs % WORD_BITS] = 1'b0;
                    full_marks[hs / WORD_BITS] = 1'b0;
                    if (live > 0)
                    begin
                        live--;
                    end
                    a.slot = SLOT_W'(hs);
                end
                if (a.status == STAT_STALE)
                begin
                    n_refused++;
                end
            end
            KIND_FREE_ALL:
            begin
                n_clear++;
                foreach (leaf_used[i])
                begin
                    leaf_used[i] = '0;
                end
                foreach (gen_of[i])
                begin
                    if (gen_of[i] == '1)
                    begin
                        n_wraps++;
                    end
                    gen_of[i]++;
                end
                full_marks = '0;
                live       = 0;
            end
            default:
            begin
                n_lookup++;
                if (in_use(s))
                begin
                    a.handle = handle_of(s);
                end
                else
                begin
                    a.status = STAT_STALE;
                end
            end
        endcase
        a.count = COUNT_W'(live);
        return a;
    endfunction

    function void note_request(kind_t k, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] s);
        pending_answers.push_back(predict_answer(k, h, s));
    endfunction

    task report_mismatch(string what, longint got, longint want);
        $display("MISMATCH answer %0d %s: got %0h, expected %0h", answers_seen, what, got, want);
        mismatches++;
    endtask

    task check_answer(logic [1:0] st, logic [HANDLE_W-1:0] h,
                      logic [SLOT_W-1:0] s, logic [COUNT_W-1:0] c);
        answer_t want;
        answers_seen++;
        if (pending_answers.size() == 0)
        begin
            report_mismatch("strobe with no command outstanding", st, 0);
            return;
        end
        want = pending_answers.pop_front();
        if (st !== want.status)
        begin
            report_mismatch("status", st, want.status);
        end
        if (h !== want.handle)
        begin
            report_mismatch("handle_out", h, want.handle);
        end
        if (s !== want.slot)
        begin
            report_mismatch("slot_out", s, want.slot);
        end
        if (c !== want.count)
        begin
            report_mismatch("live_count", c, want.count);
        end
    endtask
endclass

module tb_hierarchical_bitmap_slot_allocator_top;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    kind_t               kind;
    logic [HANDLE_W-1:0] handle_in;
    logic [SLOT_W-1:0]   slot_in;
    logic                strobe;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   slot_out;
    logic [COUNT_W-1:0]  live_count;

    slot_ledger  book;
    int unsigned items_sent = 0;

    // Percentage of transfers preceded by a sender gap, rotated every 120
    // transfers. The receiver cannot hold results off, so its stall phase
    // amounts to no idling at all, and the combined phase to sender gaps only.
    int unsigned idle_plan [4] = '{0, 66, 0, 11};

    hierarchical_bitmap_slot_allocator_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .handle_in  (handle_in),
        .slot_in    (slot_in),
        .strobe     (strobe),
        .status     (status),
        .handle_out (handle_out),
        .slot_out   (slot_out),
        .live_count (live_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Results are sampled at the edge that ends their strobe cycle, so the
    // values read here are those held during that cycle.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            book.check_answer(status, handle_out, slot_out, live_count);
        end
    end

    // Presents one command and holds it until a transfer takes place, that
    // is until an edge sees start high and busy low. Every task here is
    // entered at a rising edge, so each drive lands in a fresh time step.
    task automatic send_item(kind_t k, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] s);
        int unsigned pct;
        pct = idle_plan[(items_sent / 120) % 4];
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start     <= 1'b1;
        kind      <= k;
        handle_in <= h;
        slot_in   <= s;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        book.note_request(k, h, s);
        items_sent++;
    endtask

    // Builds a handle that the allocator must refuse, in one of several ways.
    function automatic logic [HANDLE_W-1:0] bad_handle();
        int u;
        logic [HANDLE_W-1:0] h;
        h = $urandom();
        case ($urandom_range(0, 4))
            1:
            begin
                // Live slot, wrong generation.
                u = book.find_slot($urandom_range(0, SLOT_COUNT - 1), 1'b1);
                if (u >= 0)
                begin
                    h = book.handle_of(u) ^ {8'($urandom_range(1, 255)), 24'd0};
                end
            end
            2:
            begin
                // Right generation, but the slot is not in use.
                u = book.find_slot($urandom_range(0, SLOT_COUNT - 1), 1'b0);
                if (u >= 0)
                begin
                    h = book.handle_of(u);
                end
            end
            3:
            begin
                // A handle from the previous life of a live slot.
                u = book.find_slot($urandom_range(0, SLOT_COUNT - 1), 1'b1);
                if (u >= 0)
                begin
                    h = book.handle_of(u) - {8'd1, 24'd0};
                end
            end
            4:
            begin
                // Slot field beyond the end of the store.
                h = {8'($urandom()), 24'($urandom_range(SLOT_COUNT, 24'hFF_FFFF))};
            end
            default:
            begin
            end
        endcase
        return h;
    endfunction

    // Issues one random command; the weights pick allocate, good free, bad
    // free, lookup and free-all in that order.
    task automatic issue_random(int unsigned w_alloc, int unsigned w_free, int unsigned w_bad,
                                int unsigned w_look, int unsigned w_clear);
        int unsigned         r;
        int                  u;
        kind_t               k;
        logic [HANDLE_W-1:0] h;
        logic [SLOT_W-1:0]   s;
        r = $urandom_range(0, w_alloc + w_free + w_bad + w_look + w_clear - 1);
        h = $urandom();
        s = SLOT_W'($urandom());
        k = KIND_ALLOC;
        if (r < w_alloc)
        begin
            k = KIND_ALLOC;
        end
        else if (r < w_alloc + w_free)
        begin
            u = book.find_slot($urandom_range(0, SLOT_COUNT - 1), 1'b1);
            if (u >= 0)
            begin
                k = KIND_FREE;
                h = book.handle_of(u);
            end
        end
        else if (r < w_alloc + w_free + w_bad)
        begin
            k = KIND_FREE;
            h = bad_handle();
        end
        else if (r < w_alloc + w_free + w_bad + w_look)
        begin
            k = KIND_LOOKUP;
            u = book.find_slot($urandom_range(0, SLOT_COUNT - 1), 1'b1);
            if (u >= 0 && $urandom_range(0, 1))
            begin
                s = SLOT_W'(u);
            end
        end
        else
        begin
            k = KIND_FREE_ALL;
        end
        send_item(k, h, s);
    endtask

    initial
    begin
        book      = new();
        rst_n     <= 1'b0;
        start     <= 1'b0;
        kind      <= KIND_ALLOC;
        handle_in <= '0;
        slot_in   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. The block clears its generation store after
        // reset and stays busy meanwhile; the first transfer simply waits.
        send_item(KIND_LOOKUP, '0, '0);                     // lookup of an empty store
        send_item(KIND_FREE, '0, '0);                       // free of an unused slot
        send_item(KIND_ALLOC, '1, '1);                      // lowest free slot is 0
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_LOOKUP, '1, SLOT_W'(0));
        send_item(KIND_LOOKUP, '0, '1);                     // top slot, not in use
        send_item(KIND_FREE, {8'hFF, 24'd0}, '0);          // wrong generation
        send_item(KIND_FREE, {8'h00, 24'hFF_FFFF}, '0);     // slot far beyond the store
        send_item(KIND_FREE, {8'h00, 24'(SLOT_COUNT)}, '0); // first slot beyond the store
        send_item(KIND_FREE, '1, '1);
        send_item(KIND_FREE, book.handle_of(0), '0);        // good free
        send_item(KIND_FREE, {8'h00, 24'd0}, '0);           // same handle again, now stale
        send_item(KIND_ALLOC, '0, '0);                      // slot 0 returns with a new generation
        send_item(KIND_LOOKUP, '0, SLOT_W'(0));
        send_item(KIND_FREE_ALL, '1, '1);
        send_item(KIND_LOOKUP, '0, SLOT_W'(1));
        send_item(KIND_FREE, {8'h00, 24'd1}, '0);           // handle from before the free-all
        send_item(KIND_ALLOC, '0, '0);
        send_item(KIND_FREE, book.handle_of(0), '0);
        send_item(KIND_FREE_ALL, '0, '0);

        // Fill the store, mostly with allocates but with a few holes punched
        // and refilled so that the full marks drop and rise again.
        while (book.live < SLOT_COUNT && items_sent < 3000)
        begin
            issue_random(90, 4, 2, 4, 0);
        end
        repeat (6)
        begin
            send_item(KIND_ALLOC, $urandom(), SLOT_W'($urandom()));
        end

        // Churn close to a full store.
        repeat (150)
        begin
            issue_random(45, 40, 5, 10, 0);
        end

        // Free-all heavy stretch, long enough to wrap every generation.
        repeat (320)
        begin
            issue_random(6, 4, 2, 3, 85);
        end

        // General mix.
        repeat (150)
        begin
            issue_random(40, 25, 12, 15, 8);
        end

        start <= 1'b0;
        while (book.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Covered %0d transfers: %0d allocates (%0d with the store full),",
                 items_sent, book.n_alloc, book.n_full);
        $display("%0d frees (%0d refused), %0d free-alls, %0d lookups, %0d generation wraps.",
                 book.n_free, book.n_refused, book.n_clear, book.n_lookup, book.n_wraps);
        if (book.mismatches == 0 && book.outstanding() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run, including the clearing
    // pass after reset and the longest sender gaps.
    initial
    begin
        #5_000_000;
        $display("TIMEOUT with %0d answers outstanding", book.outstanding());
        $display("simulation failed");
        $finish;
    end

endmodule

### hierarchical_bitmap_slot_allocator_top.f
src/hbsa_pkg.sv
src/hbsa_leaf_mem.sv
src/hbsa_gen_mem.sv
src/hierarchical_bitmap_slot_allocator_top.sv
verif/tb_hierarchical_bitmap_slot_allocator_top.sv
